// ===== hdl/lrc_pkg.sv =====
// Shared constants, request/result types and codes for the LRU tag cache.
package lrc_pkg;

	localparam int ENTRIES      = 16;
	localparam int KEY_BITS     = 32;
	localparam int PAYLOAD_BITS = 32;
	localparam int IDX_W        = $clog2(ENTRIES);
	localparam int CNT_W        = $clog2(ENTRIES + 1);
	localparam int SLOT_BITS    = 4;

	typedef enum logic [1:0] {
		ST_HIT   = 2'd0,
		ST_FILL  = 2'd1,
		ST_EVICT = 2'd2,
		ST_MISS  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMP_KEY_EQ  = 2'd0,
		CMP_RANK_EQ = 2'd1,
		CMP_RANK_GT = 2'd2
	} cmp_op_t;

	typedef struct packed {
		logic [31:0] lookup_key;
		logic [31:0] fill_payload;
		logic        payload_ok;
	} req_t;

	typedef struct packed {
		status_t               status;
		logic [SLOT_BITS-1:0]  slot;
		logic [31:0]           payload_out;
		logic [31:0]           evicted_payload;
	} rsp_t;

	typedef struct packed {
		logic [KEY_BITS-1:0]     key;
		logic [PAYLOAD_BITS-1:0] payload;
		logic [IDX_W-1:0]        rank;
	} entry_rd_t;

	typedef struct packed {
		logic                    ent_en;
		logic [IDX_W-1:0]        ent_idx;
		logic [KEY_BITS-1:0]     key;
		logic [PAYLOAD_BITS-1:0] payload;
		logic                    rank_en;
		logic [IDX_W-1:0]        rank_idx;
		logic [IDX_W-1:0]        rank;
	} entry_wr_t;

endpackage

// ===== hdl/lrc_cmp.sv =====
// Shared compare unit: key equality, rank equality or rank greater-than.
module lrc_cmp (
	input  lrc_pkg::cmp_op_t                 op,
	input  logic [lrc_pkg::KEY_BITS-1:0]     a_key,
	input  logic [lrc_pkg::KEY_BITS-1:0]     b_key,
	input  logic [lrc_pkg::IDX_W-1:0]        a_rank,
	input  logic [lrc_pkg::IDX_W-1:0]        b_rank,
	output logic                             match
);
	import lrc_pkg::*;

	always_comb begin
		case (op)
			CMP_KEY_EQ:  match = (a_key == b_key);
			CMP_RANK_EQ: match = (a_rank == b_rank);
			CMP_RANK_GT: match = (a_rank > b_rank);
			default:     match = 1'b0;
		endcase
	end

endmodule

// ===== hdl/lrc_store.sv =====
// Entry storage: keys, payloads and recency ranks, one read index, two write ports.
module lrc_store (
	input  logic                      clk,
	input  logic [lrc_pkg::IDX_W-1:0] rd_idx,
	output lrc_pkg::entry_rd_t        rd,
	input  lrc_pkg::entry_wr_t        wr
);
	import lrc_pkg::*;

	logic [KEY_BITS-1:0]     key_q  [ENTRIES];
	logic [PAYLOAD_BITS-1:0] pay_q  [ENTRIES];
	logic [IDX_W-1:0]        rank_q [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr.ent_en) begin
			key_q[wr.ent_idx] <= wr.key;
			pay_q[wr.ent_idx] <= wr.payload;
		end
		if (wr.rank_en) begin
			rank_q[wr.rank_idx] <= wr.rank;
		end
	end

	assign rd.key     = key_q[rd_idx];
	assign rd.payload = pay_q[rd_idx];
	assign rd.rank    = rank_q[rd_idx];

endmodule

// ===== hdl/lru_tag_cache.sv =====
// Top level of the fully associative LRU tag cache: sequencer, walk counter and result register.
// Fully associative cache of ENTRIES entries with least-recently-used replacement. Raise
// start with a request on req while busy is low; the request is taken at that edge and busy
// stays high until the result appears. The result is marked by done, high for exactly one
// cycle, and cannot be held off: capture it then. One compare unit walks the entries one
// per cycle, so latency depends on the table. A hit searches up to the matching entry, then
// walks every valid entry to update ranks; a miss searches every valid entry, and a miss
// without a fill payload or a fill into an empty slot ends there; a miss on a full table then
// walks to find the least recent entry and walks all entries again to update ranks. A new
// request may be started in the cycle that done is high.
module lru_tag_cache (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  lrc_pkg::req_t req,
	output logic          done,
	output lrc_pkg::rsp_t rsp
);
	import lrc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SEARCH = 4'b0010,
		S_EVICT  = 4'b0100,
		S_TOUCH  = 4'b1000
	} state_t;

	state_t                  state_q, state_d;
	req_t                    req_q;
	logic [CNT_W-1:0]        i_q, i_d;          // walk counter, one wider than the index
	logic [CNT_W-1:0]        used_q, used_d;
	logic [IDX_W-1:0]        idx_q, idx_d;      // entry being hit or written
	logic [IDX_W-1:0]        ref_q, ref_d;      // rank of that entry before the touch
	logic [PAYLOAD_BITS-1:0] pay_q, pay_d;
	logic [PAYLOAD_BITS-1:0] evict_q, evict_d;
	status_t                 status_q, status_d;
	logic                    done_q, done_d;
	rsp_t                    rsp_q, rsp_d;

	entry_rd_t               rd;
	entry_wr_t               wr;
	cmp_op_t                 cmp_op;
	logic [IDX_W-1:0]        cmp_ref;
	logic                    match;
	logic [IDX_W-1:0]        walk_idx;
	logic                    walk_end;
	logic                    accept;

	assign walk_idx = i_q[IDX_W-1:0];
	assign accept   = start && (state_q == S_IDLE);

	lrc_store u_store (
		.clk    (clk),
		.rd_idx (walk_idx),
		.rd     (rd),
		.wr     (wr)
	);

	// One comparator serves all three walks; the operand and mode follow the state.
	always_comb begin
		case (state_q)
			S_EVICT: begin
				cmp_op  = CMP_RANK_EQ;
				cmp_ref = '0;
			end
			S_TOUCH: begin
				cmp_op  = CMP_RANK_GT;
				cmp_ref = ref_q;
			end
			default: begin
				cmp_op  = CMP_KEY_EQ;
				cmp_ref = '0;
			end
		endcase
	end

	lrc_cmp u_cmp (
		.op     (cmp_op),
		.a_key  (rd.key),
		.b_key  (KEY_BITS'(req_q.lookup_key)),
		.a_rank (rd.rank),
		.b_rank (cmp_ref),
		.match  (match)
	);

	// Touch walk covers entries 0 .. used_count-1.
	assign walk_end = (i_q == (used_q - CNT_W'(1)));

	always_comb begin
		state_d  = state_q;
		i_d      = i_q;
		used_d   = used_q;
		idx_d    = idx_q;
		ref_d    = ref_q;
		pay_d    = pay_q;
		evict_d  = evict_q;
		status_d = status_q;
		done_d   = 1'b0;
		rsp_d    = rsp_q;
		wr       = '0;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					i_d     = '0;
					state_d = S_SEARCH;
				end
			end

			S_SEARCH: begin
				if (i_q == used_q) begin
					// Miss: every valid entry has been compared.
					if (!req_q.payload_ok) begin
						rsp_d.status          = ST_MISS;
						rsp_d.slot            = '0;
						rsp_d.payload_out     = '0;
						rsp_d.evicted_payload = '0;
						done_d                = 1'b1;
						state_d               = S_IDLE;
					end else if (used_q != CNT_W'(ENTRIES)) begin
						// Empty slot: the new entry lands on top of the order and the
						// others keep their ranks, so no rank walk is needed.
						wr.ent_en             = 1'b1;
						wr.ent_idx            = used_q[IDX_W-1:0];
						wr.key                = KEY_BITS'(req_q.lookup_key);
						wr.payload            = PAYLOAD_BITS'(req_q.fill_payload);
						wr.rank_en            = 1'b1;
						wr.rank_idx           = used_q[IDX_W-1:0];
						wr.rank               = used_q[IDX_W-1:0];
						used_d                = used_q + CNT_W'(1);
						rsp_d.status          = ST_FILL;
						rsp_d.slot            = SLOT_BITS'(used_q[IDX_W-1:0]);
						rsp_d.payload_out     = 32'(PAYLOAD_BITS'(req_q.fill_payload));
						rsp_d.evicted_payload = '0;
						done_d                = 1'b1;
						state_d               = S_IDLE;
					end else begin
						i_d     = '0;
						state_d = S_EVICT;
					end
				end else if (match) begin
					idx_d    = walk_idx;
					ref_d    = rd.rank;
					pay_d    = rd.payload;
					evict_d  = '0;
					status_d = ST_HIT;
					i_d      = '0;
					state_d  = S_TOUCH;
				end else begin
					i_d = i_q + CNT_W'(1);
				end
			end

			S_EVICT: begin
				// Find the least recent entry (rank zero, unique on a full table).
				if (match) begin
					wr.ent_en  = 1'b1;
					wr.ent_idx = walk_idx;
					wr.key     = KEY_BITS'(req_q.lookup_key);
					wr.payload = PAYLOAD_BITS'(req_q.fill_payload);
					idx_d      = walk_idx;
					ref_d      = '0;
					evict_d    = rd.payload;
					pay_d      = PAYLOAD_BITS'(req_q.fill_payload);
					status_d   = ST_EVICT;
					i_d        = '0;
					state_d    = S_TOUCH;
				end else begin
					i_d = i_q + CNT_W'(1);
				end
			end

			S_TOUCH: begin
				// Drop every rank above the touched entry's; move it to the top.
				if (walk_idx == idx_q) begin
					wr.rank_en  = 1'b1;
					wr.rank_idx = walk_idx;
					wr.rank     = IDX_W'(used_q - CNT_W'(1));
				end else if (match) begin
					wr.rank_en  = 1'b1;
					wr.rank_idx = walk_idx;
					wr.rank     = rd.rank - IDX_W'(1);
				end
				if (walk_end) begin
					rsp_d.status          = status_q;
					rsp_d.slot            = SLOT_BITS'(idx_q);
					rsp_d.payload_out     = 32'(pay_q);
					rsp_d.evicted_payload = 32'(evict_q);
					done_d                = 1'b1;
					state_d               = S_IDLE;
				end else begin
					i_d = i_q + CNT_W'(1);
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			done_q  <= done_d;
		end
	end

	// Payload and walk registers carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		i_q      <= i_d;
		idx_q    <= idx_d;
		ref_q    <= ref_d;
		pay_q    <= pay_d;
		evict_q  <= evict_d;
		status_q <= status_d;
		rsp_q    <= rsp_d;
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef SYNTHESIS
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(ENTRIES))
		else $error("entry count exceeds table size");

	a_used_mono: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> (used_q == $past(used_q)) || (used_q == $past(used_q) + CNT_W'(1)))
		else $error("entry count changed outside a fill");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status == ST_MISS)) |->
			(rsp.slot == '0) && (rsp.payload_out == '0) && (rsp.evicted_payload == '0))
		else $error("unstored miss reported nonzero fields");
`endif

endmodule
